FILE: rtl/rpb_pkg.sv
// shared types and constants of the rgb pixel blend unit
package rpb_pkg;

	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CH_W = 8;
	localparam int unsigned Y_W = 17;
	localparam int unsigned RECIP_W = 18;
	localparam int unsigned PROD_W = Y_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 25;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
	localparam logic [Y_W-1:0] ROUND_BIAS = 17'd127;
	localparam logic [RECIP_W-1:0] RECIP_255 = 18'd131587;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_SCREEN = 3'd3,
		MODE_OVERLAY = 3'd4
	} blend_mode_t;

	typedef struct packed {
		logic [7:0] base_blue;
		logic [7:0] base_green;
		logic [7:0] base_red;
		logic [7:0] layer_blue;
		logic [7:0] layer_green;
		logic [7:0] layer_red;
	} in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic pixels_equal;
	} out_t;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

FILE: rtl/rpb_lane.sv
// one channel lane: operand select and multiply, reciprocal divide by 255, result select
module rpb_lane (
	input logic clk,
	input rpb_pkg::stage_en_t en,
	input rpb_pkg::blend_mode_t mode,
	input logic [rpb_pkg::CH_W-1:0] base,
	input logic [rpb_pkg::CH_W-1:0] layer,
	output logic [rpb_pkg::CH_W-1:0] result
);

	logic [rpb_pkg::CH_W-1:0] inv_a;
	logic [rpb_pkg::CH_W-1:0] inv_b;
	logic [rpb_pkg::CH_W:0] sum;
	logic [rpb_pkg::CH_W-1:0] mul_x;
	logic [rpb_pkg::CH_W-1:0] mul_y;
	logic [2*rpb_pkg::CH_W-1:0] prod16;
	logic dbl;
	logic [rpb_pkg::Y_W-1:0] y;
	logic [rpb_pkg::CH_W-1:0] direct;
	logic use_div;
	logic invert;

	logic [rpb_pkg::Y_W-1:0] y_s1;
	logic [rpb_pkg::CH_W-1:0] direct_s1;
	logic use_div_s1;
	logic invert_s1;

	logic [rpb_pkg::PROD_W-1:0] prod_s2;
	logic [rpb_pkg::CH_W-1:0] direct_s2;
	logic use_div_s2;
	logic invert_s2;

	logic [rpb_pkg::CH_W-1:0] quot;
	logic [rpb_pkg::CH_W-1:0] result_s3;

	assign inv_a = rpb_pkg::CH_MAX - base;
	assign inv_b = rpb_pkg::CH_MAX - layer;
	assign sum = {1'b0, base} + {1'b0, layer};

	always_comb begin
		direct = base;
		use_div = 1'b0;
		invert = 1'b0;
		dbl = 1'b0;
		mul_x = base;
		mul_y = layer;
		unique case (mode)
			rpb_pkg::MODE_ADD: begin
				direct = sum[rpb_pkg::CH_W] ? rpb_pkg::CH_MAX : sum[rpb_pkg::CH_W-1:0];
			end
			rpb_pkg::MODE_SUB: begin
				direct = (base > layer) ? (base - layer) : '0;
			end
			rpb_pkg::MODE_MUL: begin
				use_div = 1'b1;
			end
			rpb_pkg::MODE_SCREEN: begin
				use_div = 1'b1;
				invert = 1'b1;
				mul_x = inv_a;
				mul_y = inv_b;
			end
			rpb_pkg::MODE_OVERLAY: begin
				use_div = 1'b1;
				dbl = 1'b1;
				if (layer[rpb_pkg::CH_W-1]) begin
					invert = 1'b1;
					mul_x = inv_a;
					mul_y = inv_b;
				end
			end
			default: begin
				direct = base;
			end
		endcase
	end

	assign prod16 = mul_x * mul_y;
	assign y = (dbl ? {prod16, 1'b0} : {1'b0, prod16}) + rpb_pkg::ROUND_BIAS;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			y_s1 <= y;
			direct_s1 <= direct;
			use_div_s1 <= use_div;
			invert_s1 <= invert;
		end
	end

	// floor(y / 255) through a scaled reciprocal
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= y_s1 * rpb_pkg::RECIP_255;
			direct_s2 <= direct_s1;
			use_div_s2 <= use_div_s1;
			invert_s2 <= invert_s1;
		end
	end

	assign quot = prod_s2[rpb_pkg::RECIP_SHIFT +: rpb_pkg::CH_W];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (!use_div_s2) begin
				result_s3 <= direct_s2;
			end else if (invert_s2) begin
				result_s3 <= rpb_pkg::CH_MAX - quot;
			end else begin
				result_s3 <= quot;
			end
		end
	end

	assign result = result_s3;

endmodule

FILE: rtl/rpb_merge.sv
// merging stage: pixel equality compare and packing of the lane results
module rpb_merge (
	input logic clk,
	input rpb_pkg::stage_en_t en,
	input rpb_pkg::pixel_t base,
	input rpb_pkg::pixel_t layer,
	input rpb_pkg::pixel_t lane_res,
	output rpb_pkg::out_t out_data
);

	logic eq_s1;
	logic eq_s2;
	logic eq_s3;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			eq_s1 <= (base == layer);
		end
		if (en.s2) begin
			eq_s2 <= eq_s1;
		end
		if (en.s3) begin
			eq_s3 <= eq_s2;
		end
	end

	always_comb begin
		out_data.out_blue = lane_res[0];
		out_data.out_green = lane_res[1];
		out_data.out_red = lane_res[2];
		out_data.pixels_equal = eq_s3;
	end

endmodule

FILE: rtl/rgb_pixel_blend_unit.sv
// top level of the rgb pixel blend unit: config register, pipeline control, lanes, merge
//
// Blends a base and a layer pixel channel by channel in the mode set in the
// blend_mode register (byte address 0) and flags equal pixels. Three channel
// lanes run side by side, each a three-stage pipeline: operand select, 8x8
// multiply and rounding bias, multiply by a fixed reciprocal of 255, result
// select into the output register. One pixel pair is taken every cycle while
// the output is not stalled; a transfer passes the s1, s2 and s3 registers
// on its way to output valid. Each stage advances whenever it is empty or the
// stage after it moves, so bubbles are squeezed out while the output waits.
// Write blend_mode only while the pipeline is empty.
module rgb_pixel_blend_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rpb_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rpb_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rpb_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [rpb_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rpb_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready
);

	rpb_pkg::blend_mode_t mode_q;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	rpb_pkg::stage_en_t en;
	rpb_pkg::pixel_t base;
	rpb_pkg::pixel_t layer;
	rpb_pkg::pixel_t lane_res;
	logic reg_sel;

	assign pready = 1'b1;
	assign reg_sel = (paddr[rpb_pkg::CFG_ADDR_W-1] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rpb_pkg::MODE_ADD;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mode_q <= rpb_pkg::blend_mode_t'(pwdata[2:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[2:0] = mode_q;
		end
	end

	always_comb begin
		en.s3 = !v_s3 || out_ready;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= in_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign out_valid = v_s3;

	assign base[0] = in_data.base_blue;
	assign base[1] = in_data.base_green;
	assign base[2] = in_data.base_red;
	assign layer[0] = in_data.layer_blue;
	assign layer[1] = in_data.layer_green;
	assign layer[2] = in_data.layer_red;

	for (genvar i = 0; i < rpb_pkg::NUM_CH; i++) begin : g_lane
		rpb_lane u_lane (
			.clk(clk),
			.en(en),
			.mode(mode_q),
			.base(base[i]),
			.layer(layer[i]),
			.result(lane_res[i])
		);
	end

	rpb_merge u_merge (
		.clk(clk),
		.en(en),
		.base(base),
		.layer(layer),
		.lane_res(lane_res),
		.out_data(out_data)
	);

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("transfer did not reach the output in three cycles");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_ready && v_s3) |=> $countones({v_s1, v_s2, v_s3}) >= 2)
		else $error("pipeline lost a transfer");
`endif

endmodule

FILE: bench/rgb_pixel_blend_unit_tb.sv
// testbench for the rgb pixel blend unit: directed and random pixel pairs against a blend predictor
`timescale 1ns / 100ps

class blend_checker;
	logic [2:0] mode;
	rpb_pkg::out_t expected_pixels[$];
	int unsigned mismatches;

	function new();
		mode = rpb_pkg::MODE_ADD;
		mismatches = 0;
	endfunction

	task report(string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	function int unsigned nearest_div255(int unsigned x);
		return (2 * x + 255) / 510;
	endfunction

	function logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b);
		int unsigned ia;
		int unsigned ib;
		int unsigned s;
		ia = a;
		ib = b;
		case (mode)
			rpb_pkg::MODE_ADD: s = (ia + ib > 255) ? 255 : ia + ib;
			rpb_pkg::MODE_SUB: s = (ia > ib) ? ia - ib : 0;
			rpb_pkg::MODE_MUL: s = nearest_div255(ia * ib);
			rpb_pkg::MODE_SCREEN: s = 255 - nearest_div255((255 - ia) * (255 - ib));
			rpb_pkg::MODE_OVERLAY: begin
				if (ib >= 128) begin
					s = 255 - nearest_div255(2 * (255 - ia) * (255 - ib));
				end else begin
					s = nearest_div255(2 * ia * ib);
				end
			end
			default: s = ia;
		endcase
		return s[7:0];
	endfunction

	function rpb_pkg::out_t predict_blend(rpb_pkg::in_t px);
		rpb_pkg::out_t r;
		r.out_blue = blend_channel(px.base_blue, px.layer_blue);
		r.out_green = blend_channel(px.base_green, px.layer_green);
		r.out_red = blend_channel(px.base_red, px.layer_red);
		r.pixels_equal = (px.base_blue == px.layer_blue) && (px.base_green == px.layer_green)
			&& (px.base_red == px.layer_red);
		return r;
	endfunction

	function void note_pair(rpb_pkg::in_t px);
		expected_pixels.push_back(predict_blend(px));
	endfunction

	function int unsigned pending();
		return expected_pixels.size();
	endfunction

	task check_pixel(rpb_pkg::out_t got);
		rpb_pkg::out_t want;
		if (expected_pixels.size() == 0) begin
			report($sformatf("unexpected output transfer %h", got));
			return;
		end
		want = expected_pixels.pop_front();
		if (got.out_blue !== want.out_blue) begin
			report($sformatf("out_blue got %h want %h", got.out_blue, want.out_blue));
		end
		if (got.out_green !== want.out_green) begin
			report($sformatf("out_green got %h want %h", got.out_green, want.out_green));
		end
		if (got.out_red !== want.out_red) begin
			report($sformatf("out_red got %h want %h", got.out_red, want.out_red));
		end
		if (got.pixels_equal !== want.pixels_equal) begin
			report($sformatf("pixels_equal got %b want %b", got.pixels_equal,
				want.pixels_equal));
		end
	endtask
endclass

module rgb_pixel_blend_unit_tb;

	localparam logic [rpb_pkg::CFG_ADDR_W-1:0] BLEND_MODE_ADDR = '0;
	localparam logic [2:0] MODE_RSVD_5 = 3'd5;
	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_PIXELS = 70;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rpb_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	rpb_pkg::out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rpb_pkg::CFG_ADDR_W-1:0] paddr;
	logic [rpb_pkg::CFG_DATA_W-1:0] pwdata;
	logic [rpb_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	blend_checker sb;
	int unsigned idle_pct;
	bit hold_req;
	int unsigned cycles;
	logic [2:0] mode_seq[8];

	rgb_pixel_blend_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// output side: check each transfer, stall at random or on a hold-off request
	initial begin
		int unsigned hold_cnt;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_pixel(out_data);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 80;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic send_pixel(rpb_pkg::in_t px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_pair(px);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_blend_mode(logic [2:0] mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BLEND_MODE_ADDR;
		pwdata <= {{(rpb_pkg::CFG_DATA_W-3){1'b0}}, mode};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.mode = mode;
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[2:0] !== mode) begin
			sb.report($sformatf("blend_mode read %h want %h", prdata[2:0], mode));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic rpb_pkg::in_t make_pixel(logic [7:0] bb, logic [7:0] bg,
		logic [7:0] br, logic [7:0] lb, logic [7:0] lg, logic [7:0] lr);
		rpb_pkg::in_t px;
		px.base_blue = bb;
		px.base_green = bg;
		px.base_red = br;
		px.layer_blue = lb;
		px.layer_green = lg;
		px.layer_red = lr;
		return px;
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(128, 127));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic rpb_pkg::in_t rand_pixel();
		rpb_pkg::in_t px;
		px = make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
			rand_chan());
		case ($urandom_range(7))
			0: begin
				px.layer_blue = px.base_blue;
				px.layer_green = px.base_green;
				px.layer_red = px.base_red;
			end
			1: begin
				px.layer_blue = px.base_blue;
				px.layer_red = px.base_red;
			end
			default: ;
		endcase
		return px;
	endfunction

	initial begin
		sb = new();
		idle_pct = 17;
		hold_req = 1'b0;
		mode_seq = '{rpb_pkg::MODE_ADD, rpb_pkg::MODE_SUB, rpb_pkg::MODE_MUL,
			rpb_pkg::MODE_SCREEN, rpb_pkg::MODE_OVERLAY, MODE_RSVD_5, MODE_RSVD_6,
			MODE_RSVD_7};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, overlay threshold and equal pixels in every mode
		for (int m = 0; m < 8; m++) begin
			if (m != 0) begin
				set_blend_mode(mode_seq[m]);
			end
			send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
			send_pixel(make_pixel(8'hFF, 8'h00, 8'hC8, 8'h7F, 8'h80, 8'h01));
			send_pixel(make_pixel(8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h80, 8'h7F));
			wait_drained();
		end

		for (int p = 0; p < 10; p++) begin
			set_blend_mode((p < 8) ? mode_seq[p] : mode_seq[$urandom_range(7)]);
			idle_pct = (p == 5) ? 0 : 17;
			if (p == 3 || p == 8) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				send_pixel(rand_pixel());
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
